/* sv/tcblb_pkg.sv */
`default_nettype none

package tcblb_pkg;

    // Request codes
    localparam logic REQ_PLACE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;       // clear sweep step
        logic capture;   // latch request fields
        logic rd;        // read both loads and both histogram entries
        logic eval;      // pick bin, write its load, read histogram slot
        logic upd;       // write histogram slot
        logic load_out;  // load the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;  // last entry of the clear sweep
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

`default_nettype wire

/* sv/two_choice_bin_load_balancer.sv */
`default_nettype none

// Two-choice bin load balancer.
// Input channel (i_valid / o_stall): a transfer carries one request. A place
// request (i_req_type 0) names two candidate bins; the ball goes to the less
// loaded one, the first on a tie. A query (i_req_type 1) asks how many bins
// hold load i_load_level.
// Output channel (o_valid / i_stall): exactly one result transfer per request.
// A request steps through the read, eval, update and done states; its result
// then enters the output register and a new request is taken. The work is
// a fixed sequence over the two memories: read both candidate loads and two
// histogram entries, pick and write the load, read then write one entry.
// The histogram keeps, per level, the count of bins at that level or above,
// so a placement touches one entry and a query takes a difference.
// Reset: a clearing pass of max(NUM_BINS, MAX_LOAD) entries (1024 by default)
// zeroes both memories; o_stall stays high until it ends. The configuration
// port works during the pass.
// Receiver stall: a finished result holds in the output register; the block
// finishes the next request internally but waits to deliver it. bins_in_use
// lies at byte address 0; users write it only while idle, unchecked by the block.
module two_choice_bin_load_balancer #(
    parameter int NUM_BINS = 1024,
    parameter int MAX_LOAD = 255,
    parameter int BW       = $clog2(NUM_BINS),
    parameter int LW       = $clog2(MAX_LOAD + 1),
    parameter int CW       = $clog2(NUM_BINS + 1)
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    // configuration port
    input  wire           psel,
    input  wire           penable,
    input  wire           pwrite,
    input  wire  [2:0]    paddr,
    input  wire  [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // request channel
    input  wire           i_valid,
    output logic          o_stall,
    input  wire           i_req_type,
    input  wire  [BW-1:0] i_first_bin,
    input  wire  [BW-1:0] i_second_bin,
    input  wire  [LW-1:0] i_load_level,
    // result channel
    output logic          o_valid,
    input  wire           i_stall,
    output logic [BW-1:0] o_chosen_bin,
    output logic [LW-1:0] o_new_load,
    output logic [CW-1:0] o_bins_at_level,
    output logic [1:0]    o_status
);

    logic [CW-1:0]   r_bins_in_use;
    logic            w_reg_hit;
    tcblb_pkg::t_cmd w_cmd;
    tcblb_pkg::t_sts w_sts;

    // Only register 0 exists; other word addresses read zero and drop writes.
    assign w_reg_hit = (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = w_reg_hit ? 32'(r_bins_in_use) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins_in_use <= CW'(NUM_BINS);
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_bins_in_use <= pwdata[CW-1:0];
        end
    end

    tcblb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    tcblb_dp #(
        .NUM_BINS (NUM_BINS),
        .MAX_LOAD (MAX_LOAD),
        .BW       (BW),
        .LW       (LW),
        .CW       (CW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_bins_in_use   (r_bins_in_use),
        .i_req_type      (i_req_type),
        .i_first_bin     (i_first_bin),
        .i_second_bin    (i_second_bin),
        .i_load_level    (i_load_level),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_chosen_bin    (o_chosen_bin),
        .o_new_load      (o_new_load),
        .o_bins_at_level (o_bins_at_level),
        .o_status        (o_status)
    );

endmodule

`default_nettype wire

/* sv/tcblb_ctrl.sv */
`default_nettype none

module tcblb_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  tcblb_pkg::t_sts   i_sts,
    output tcblb_pkg::t_cmd   o_cmd,
    output logic              o_stall
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_UPD,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_READ;
            S_READ:  n_state = S_EVAL;
            S_EVAL:  n_state = S_UPD;
            S_UPD:   n_state = S_DONE;
            S_DONE:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.clr      = (r_state == S_CLEAR);
        o_cmd.capture  = (r_state == S_IDLE) && i_valid;
        o_cmd.rd       = (r_state == S_READ);
        o_cmd.eval     = (r_state == S_EVAL);
        o_cmd.upd      = (r_state == S_UPD);
        o_cmd.load_out = (r_state == S_DONE) && i_sts.out_free;
        o_stall        = (r_state != S_IDLE);
    end

endmodule

`default_nettype wire

/* sv/tcblb_dp.sv */
`default_nettype none

module tcblb_dp #(
    parameter int NUM_BINS = 1024,
    parameter int MAX_LOAD = 255,
    parameter int BW       = $clog2(NUM_BINS),
    parameter int LW       = $clog2(MAX_LOAD + 1),
    parameter int CW       = $clog2(NUM_BINS + 1)
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  tcblb_pkg::t_cmd   i_cmd,
    output tcblb_pkg::t_sts   o_sts,
    input  wire  [CW-1:0]     i_bins_in_use,
    input  wire               i_req_type,
    input  wire  [BW-1:0]     i_first_bin,
    input  wire  [BW-1:0]     i_second_bin,
    input  wire  [LW-1:0]     i_load_level,
    input  wire               i_stall,
    output logic              o_valid,
    output logic [BW-1:0]     o_chosen_bin,
    output logic [LW-1:0]     o_new_load,
    output logic [CW-1:0]     o_bins_at_level,
    output logic [1:0]        o_status
);

    localparam int HW      = $clog2(MAX_LOAD);
    localparam int CLR_LEN = (NUM_BINS > MAX_LOAD) ? NUM_BINS : MAX_LOAD;
    localparam int CLRW    = $clog2(CLR_LEN + 1);

    // Load per bin, and per level L the number of bins at load L or above
    // (entry L-1).
    logic [LW-1:0] bin_mem [NUM_BINS];
    logic [CW-1:0] ge_mem  [MAX_LOAD];

    logic [CLRW-1:0] r_clr_cnt;
    logic            r_req;
    logic [BW-1:0]   r_a;
    logic [BW-1:0]   r_b;
    logic [LW-1:0]   r_lvl;
    logic [LW-1:0]   r_load_a;
    logic [LW-1:0]   r_load_b;
    logic [CW-1:0]   r_ge_a;
    logic [CW-1:0]   r_ge_b;
    logic [BW-1:0]   r_chosen;
    logic [LW-1:0]   r_cur;
    logic            r_sat;
    logic            r_o_valid;

    logic [CW-1:0]   w_limit;
    logic            w_oor;
    logic            w_place_ok;
    logic            w_qzero;
    logic            w_qhigh;
    logic            w_qlast;
    logic [LW-1:0]   w_lvl_m1;
    logic [HW-1:0]   w_ha;
    logic [HW-1:0]   w_hb;
    logic            w_pick_a;
    logic [BW-1:0]   w_chosen;
    logic [LW-1:0]   w_cur;
    logic            w_sat;
    logic [HW-1:0]   w_hslot;
    logic [CW-1:0]   w_qcount;

    always_comb begin
        w_limit    = (i_bins_in_use < CW'(NUM_BINS)) ? i_bins_in_use : CW'(NUM_BINS);
        w_oor      = (CW'(r_a) >= w_limit) || (CW'(r_b) >= w_limit);
        w_place_ok = (r_req == tcblb_pkg::REQ_PLACE) && !w_oor;
        w_qzero    = (r_lvl == '0);
        w_qhigh    = (r_lvl > LW'(MAX_LOAD));
        w_qlast    = (r_lvl == LW'(MAX_LOAD));
        w_lvl_m1   = r_lvl - LW'(1);
        w_ha       = (w_qzero || w_qhigh) ? '0 : w_lvl_m1[HW-1:0];
        w_hb       = (w_qlast || w_qhigh) ? '0 : r_lvl[HW-1:0];
        w_pick_a   = (r_load_a <= r_load_b);
        w_chosen   = w_pick_a ? r_a : r_b;
        w_cur      = w_pick_a ? r_load_a : r_load_b;
        w_sat      = (w_cur >= LW'(MAX_LOAD));
        w_hslot    = w_sat ? '0 : w_cur[HW-1:0];
        if (w_qhigh) begin
            w_qcount = '0;
        end else if (w_qzero) begin
            w_qcount = (w_limit > r_ge_a) ? (w_limit - r_ge_a) : '0;
        end else if (w_qlast) begin
            w_qcount = r_ge_a;
        end else begin
            w_qcount = r_ge_a - r_ge_b;
        end
    end

    // Clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + CLRW'(1);
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req_type;
            r_a   <= i_first_bin;
            r_b   <= i_second_bin;
            r_lvl <= i_load_level;
        end
    end

    // Load memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            if (r_clr_cnt < CLRW'(NUM_BINS)) begin
                bin_mem[r_clr_cnt[BW-1:0]] <= '0;
            end
        end else if (i_cmd.eval && w_place_ok && !w_sat) begin
            bin_mem[w_chosen] <= w_cur + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_load_a <= bin_mem[r_a];
            r_load_b <= bin_mem[r_b];
        end
    end

    // Histogram memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            if (r_clr_cnt < CLRW'(MAX_LOAD)) begin
                ge_mem[r_clr_cnt[HW-1:0]] <= '0;
            end
        end else if (i_cmd.upd && w_place_ok && !r_sat) begin
            ge_mem[r_cur[HW-1:0]] <= r_ge_a + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_ge_a <= ge_mem[w_ha];
            r_ge_b <= ge_mem[w_hb];
        end else if (i_cmd.eval && (r_req == tcblb_pkg::REQ_PLACE)) begin
            r_ge_a <= ge_mem[w_hslot];
        end
    end

    // Choice
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_chosen <= w_chosen;
            r_cur    <= w_cur;
            r_sat    <= w_sat;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_chosen_bin    <= '0;
            o_new_load      <= '0;
            o_bins_at_level <= '0;
            o_status        <= tcblb_pkg::ST_OK;
            if (r_req == tcblb_pkg::REQ_QUERY) begin
                o_bins_at_level <= w_qcount;
            end else if (w_oor) begin
                o_status <= tcblb_pkg::ST_RANGE;
            end else if (r_sat) begin
                o_chosen_bin <= r_chosen;
                o_new_load   <= LW'(MAX_LOAD);
                o_status     <= tcblb_pkg::ST_SAT;
            end else begin
                o_chosen_bin <= r_chosen;
                o_new_load   <= r_cur + LW'(1);
            end
        end
    end

    assign o_valid         = r_o_valid;
    assign o_sts.out_free  = !r_o_valid || !i_stall;
    assign o_sts.clr_last  = (r_clr_cnt == CLRW'(CLR_LEN - 1));

endmodule

`default_nettype wire

/* sv/tcblb_chk.sv */
`default_nettype none

module tcblb_chk #(
    parameter int NUM_BINS = 1024,
    parameter int MAX_LOAD = 255,
    parameter int BW       = $clog2(NUM_BINS),
    parameter int LW       = $clog2(MAX_LOAD + 1),
    parameter int CW       = $clog2(NUM_BINS + 1)
) (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          i_valid,
    input wire          o_stall,
    input wire          o_valid,
    input wire          i_stall,
    input wire [BW-1:0] o_chosen_bin,
    input wire [LW-1:0] o_new_load,
    input wire [CW-1:0] o_bins_at_level,
    input wire [1:0]    o_status
);

    // No result is pending right after reset.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // One request at a time: the request side stalls after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken while busy");

    // Range error carries no bin and no load.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == tcblb_pkg::ST_RANGE)) |->
        ((o_chosen_bin == '0) && (o_new_load == '0) && (o_bins_at_level == '0)))
        else $error("range error with payload");

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_chosen_bin) && $stable(o_new_load) &&
         $stable(o_bins_at_level) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind two_choice_bin_load_balancer tcblb_chk #(
    .NUM_BINS (NUM_BINS),
    .MAX_LOAD (MAX_LOAD),
    .BW       (BW),
    .LW       (LW),
    .CW       (CW)
) u_tcblb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_chosen_bin    (o_chosen_bin),
    .o_new_load      (o_new_load),
    .o_bins_at_level (o_bins_at_level),
    .o_status        (o_status)
);

`default_nettype wire

/* tb/sv/two_choice_bin_load_balancer_test.sv */
`timescale 1ns / 1ps

module two_choice_bin_load_balancer_test;

    localparam int NUM_BINS    = 1024;
    localparam int MAX_LOAD    = 255;
    localparam int BW          = 10;
    localparam int LW          = 8;
    localparam int CW          = 11;
    // Register byte addresses: bins_in_use is the only register, address 4 is unmapped
    localparam logic [2:0] REG_BINS_IN_USE = 3'd0;
    localparam logic [2:0] REG_UNMAPPED    = 3'd4;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_TIME  = 16;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic          req_type;
        logic [BW-1:0] first_bin;
        logic [BW-1:0] second_bin;
        logic [LW-1:0] load_level;
    } t_ball_request;

    typedef struct packed {
        logic [BW-1:0] chosen_bin;
        logic [LW-1:0] new_load;
        logic [CW-1:0] bins_at_level;
        logic [1:0]    status;
    } t_ball_result;

    logic          i_clk        = 1'b0;
    logic          i_rst_n      = 1'b0;
    logic          psel         = 1'b0;
    logic          penable      = 1'b0;
    logic          pwrite       = 1'b0;
    logic [2:0]    paddr        = '0;
    logic [31:0]   pwdata       = '0;
    wire  [31:0]   prdata;
    wire           pready;
    logic          i_valid      = 1'b0;
    wire           o_stall;
    logic          i_req_type   = tcblb_pkg::REQ_PLACE;
    logic [BW-1:0] i_first_bin  = '0;
    logic [BW-1:0] i_second_bin = '0;
    logic [LW-1:0] i_load_level = '0;
    wire           o_valid;
    logic          i_stall      = 1'b0;
    wire  [BW-1:0] o_chosen_bin;
    wire  [LW-1:0] o_new_load;
    wire  [CW-1:0] o_bins_at_level;
    wire  [1:0]    o_status;

    two_choice_bin_load_balancer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_first_bin    (i_first_bin),
        .i_second_bin   (i_second_bin),
        .i_load_level   (i_load_level),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_chosen_bin   (o_chosen_bin),
        .o_new_load     (o_new_load),
        .o_bins_at_level(o_bins_at_level),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the block: per-bin loads, per-level bin counts, loaded-bin total
    // and the bins_in_use register as last written.
    logic [10:0]   bins_in_use_shadow = 11'd1024;
    int            bin_load    [NUM_BINS];
    int            level_tally [1:MAX_LOAD];
    int            loaded_total;

    t_ball_request request_backlog [$];   // requests waiting to be transferred
    t_ball_result  awaited_results [$];   // results predicted, not yet seen

    int  mismatches   = 0;
    int  send_gap     = 0;
    int  recv_gap     = 0;
    int  hold_left    = 0;
    int  hold_asked   = 0;
    int  hold_started = 0;
    int  cycle_count  = 0;
    bit  idling_on    = 1'b1;

    // Work out the result of one request and advance the shadow state.
    function automatic t_ball_result next_bin_result(input t_ball_request r);
        t_ball_result  res;
        int            active;
        logic [BW-1:0] pick;
        int            cur;
        res    = '0;
        active = (int'(bins_in_use_shadow) < NUM_BINS) ? int'(bins_in_use_shadow) : NUM_BINS;
        if (r.req_type == tcblb_pkg::REQ_QUERY) begin
            // Level zero is derived; it clamps at zero once bins_in_use drops
            // below the number of loaded bins.
            if (r.load_level == 0)
                res.bins_at_level = CW'((active > loaded_total) ? active - loaded_total : 0);
            else if (r.load_level <= MAX_LOAD)
                res.bins_at_level = CW'(level_tally[r.load_level]);
        end else if (r.first_bin >= active || r.second_bin >= active) begin
            res.status = tcblb_pkg::ST_RANGE;
        end else begin
            // A tie goes to the first candidate.
            pick = (bin_load[r.first_bin] <= bin_load[r.second_bin]) ?
                   r.first_bin : r.second_bin;
            cur  = bin_load[pick];
            res.chosen_bin = pick;
            if (cur >= MAX_LOAD) begin
                res.new_load = LW'(MAX_LOAD);
                res.status   = tcblb_pkg::ST_SAT;
            end else begin
                if (cur == 0)
                    loaded_total++;
                else
                    level_tally[cur]--;
                level_tally[cur + 1]++;
                bin_load[pick] = cur + 1;
                res.new_load   = LW'(cur + 1);
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic push_request(input logic kind, input int first, input int second,
                                input int level);
        t_ball_request r;
        r.req_type   = kind;
        r.first_bin  = BW'(first);
        r.second_bin = BW'(second);
        r.load_level = LW'(level);
        request_backlog = {request_backlog, r};
    endtask

    // Queue random requests. Candidates mostly fall below span; a stray share
    // draws from the whole 10-bit range. Query levels lean toward low loads.
    task automatic queue_random(input int count, input int span, input int query_pct,
                                input int stray_pct);
        t_ball_request r;
        repeat (count) begin
            r.req_type   = ($urandom_range(0, 99) < query_pct) ?
                           tcblb_pkg::REQ_QUERY : tcblb_pkg::REQ_PLACE;
            r.first_bin  = ($urandom_range(0, 99) < stray_pct) ? BW'($urandom) :
                           BW'($urandom_range(0, span - 1));
            r.second_bin = ($urandom_range(0, 99) < stray_pct) ? BW'($urandom) :
                           BW'($urandom_range(0, span - 1));
            r.load_level = $urandom_range(0, 1) ? LW'($urandom_range(0, 4)) :
                           LW'($urandom);
            request_backlog = {request_backlog, r};
        end
    endtask

    // Wait until every request is transferred and every result has come back.
    task automatic wait_drained();
        while (request_backlog.size() != 0 || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_TIME) @(negedge i_clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the edge with pready high.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_BINS_IN_USE)
            bins_in_use_shadow = data[10:0];
    endtask

    // Request driver: predict on each transfer, hold the payload while stalled,
    // and insert idle bursts between requests.
    always @(posedge i_clk) begin : drive_requests
        bit            took;
        t_ball_request head;
        if (i_rst_n) begin
            took = i_valid && !o_stall;
            if (took) begin
                head = request_backlog.pop_front();
                awaited_results = {awaited_results, next_bin_result(head)};
            end
            if (!i_valid || took) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (request_backlog.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 14);
                    i_valid <= 1'b0;
                end else begin
                    i_valid      <= 1'b1;
                    i_req_type   <= request_backlog[0].req_type;
                    i_first_bin  <= request_backlog[0].first_bin;
                    i_second_bin <= request_backlog[0].second_bin;
                    i_load_level <= request_backlog[0].load_level;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
    always @(posedge i_clk) begin
        if (hold_started != hold_asked) begin
            hold_left    <= LONG_HOLD;
            hold_started <= hold_started + 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compare each transfer with the oldest prediction, then
    // decide the stall for the next cycle.
    always @(posedge i_clk) begin : watch_results
        t_ball_result want;
        if (o_valid === 1'b1 && i_stall === 1'b0) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing outstanding (bin %0d)",
                                        o_chosen_bin));
            end else begin
                want = awaited_results.pop_front();
                if (o_chosen_bin !== want.chosen_bin)
                    flag_mismatch($sformatf("chosen_bin %0d, want %0d",
                                            o_chosen_bin, want.chosen_bin));
                if (o_new_load !== want.new_load)
                    flag_mismatch($sformatf("new_load %0d, want %0d",
                                            o_new_load, want.new_load));
                if (o_bins_at_level !== want.bins_at_level)
                    flag_mismatch($sformatf("bins_at_level %0d, want %0d",
                                            o_bins_at_level, want.bins_at_level));
                if (o_status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            o_status, want.status));
            end
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 14);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: covers the clearing pass, the long hold and worst-case idling.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        foreach (bin_load[i]) bin_load[i] = 0;
        foreach (level_tally[i]) level_tally[i] = 0;
        loaded_total = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset value of bins_in_use: all 1024 bins take part.
        push_request(tcblb_pkg::REQ_QUERY, 0, 0, 0);
        push_request(tcblb_pkg::REQ_QUERY, 1023, 1023, MAX_LOAD);
        push_request(tcblb_pkg::REQ_PLACE, 0, 1023, 0);     // tie, first bin wins
        push_request(tcblb_pkg::REQ_PLACE, 0, 1023, 255);   // second bin lighter
        push_request(tcblb_pkg::REQ_PLACE, 1023, 0, 0);     // tie again, reversed order
        push_request(tcblb_pkg::REQ_PLACE, 0, 1023, 0);     // first bin lighter
        push_request(tcblb_pkg::REQ_PLACE, 512, 512, 0);    // both candidates the same bin
        push_request(tcblb_pkg::REQ_QUERY, 0, 0, 1);
        push_request(tcblb_pkg::REQ_QUERY, 0, 0, 2);
        push_request(tcblb_pkg::REQ_QUERY, 1023, 1023, 0);
        wait_drained();

        // Zero bins: every candidate is out of range, level zero reads zero.
        apb_write(REG_BINS_IN_USE, 32'd0);
        @(negedge i_clk);
        push_request(tcblb_pkg::REQ_PLACE, 0, 0, 0);
        push_request(tcblb_pkg::REQ_QUERY, 0, 0, 0);
        push_request(tcblb_pkg::REQ_QUERY, 0, 0, 2);
        wait_drained();

        // A write to an unmapped address leaves bins_in_use at zero.
        apb_write(REG_UNMAPPED, 32'd5);
        @(negedge i_clk);
        push_request(tcblb_pkg::REQ_PLACE, 0, 1, 0);
        wait_drained();

        // Above NUM_BINS the effective count is limited to NUM_BINS.
        apb_write(REG_BINS_IN_USE, 32'h7FF);
        @(negedge i_clk);
        push_request(tcblb_pkg::REQ_PLACE, 1023, 1023, 0);
        push_request(tcblb_pkg::REQ_QUERY, 0, 0, 0);
        wait_drained();

        // One bin: loaded bins above it leave the level-zero count clamped at zero.
        apb_write(REG_BINS_IN_USE, 32'd1);
        @(negedge i_clk);
        push_request(tcblb_pkg::REQ_PLACE, 0, 0, 0);
        push_request(tcblb_pkg::REQ_PLACE, 0, 1, 0);
        push_request(tcblb_pkg::REQ_QUERY, 0, 0, 0);
        push_request(tcblb_pkg::REQ_QUERY, 0, 0, 3);
        wait_drained();

        // Full range with a long receiver hold-off so the block backs up.
        apb_write(REG_BINS_IN_USE, 32'd1024);
        @(negedge i_clk);
        queue_random(140, NUM_BINS, 25, 0);
        hold_asked <= hold_asked + 1;
        wait_drained();

        // A random small bin count with some stray candidates.
        apb_write(REG_BINS_IN_USE, $urandom_range(2, 300));
        @(negedge i_clk);
        queue_random(100, int'(bins_in_use_shadow), 25, 15);
        wait_drained();

        // One bin hammered until its load saturates.
        apb_write(REG_BINS_IN_USE, 32'd1);
        @(negedge i_clk);
        queue_random(330, 1, 10, 5);
        wait_drained();

        // Last stretch: no idling on either side.
        apb_write(REG_BINS_IN_USE, 32'h7FF);
        @(negedge i_clk);
        idling_on = 1'b0;
        queue_random(60, NUM_BINS, 30, 0);
        wait_drained();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* two_choice_bin_load_balancer.f */
sv/tcblb_pkg.sv
sv/tcblb_ctrl.sv
sv/tcblb_dp.sv
sv/two_choice_bin_load_balancer.sv
sv/tcblb_chk.sv
tb/sv/two_choice_bin_load_balancer_test.sv
